// ===== rtl/hsw_pkg.sv =====
// Shared constants, a side-band type and a helper function of the fp16 hard-swish vector unit.
package hsw_pkg;

  localparam int unsigned LANES    = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned LANE_LAT = 8;

  localparam logic [15:0] FP16_QNAN = 16'h7E00;
  localparam logic [15:0] FP16_PINF = 16'h7C00;
  localparam logic [14:0] MAG_INF   = 15'h7C00;

  // Six in unsigned 3.10 fixed point.
  localparam logic [12:0] C_SIX = 13'd6144;
  // Three in signed fixed point with 24 fraction bits.
  localparam logic signed [27:0] THREE_FX = 28'sh300_0000;
  // Reciprocal of three, (2^25 + 1) / 3, exact for 24-bit dividends.
  localparam logic [23:0] RECIP3 = 24'hAAAAAB;

  typedef struct packed {
    logic        sign;
    logic        byp;
    logic [15:0] byp_val;
  } side_t;

  // Position of the most significant set bit; zero for a zero word.
  function automatic logic [4:0] lead_pos(input logic [23:0] v);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/hsw_rnd.sv =====
// Two-stage normalize and round-to-nearest-even unit producing an fp16 magnitude.
module hsw_rnd (
  input  logic                clk_i,
  input  logic [23:0]         n_i,
  input  logic signed [6:0]   ex_i,
  input  logic                sticky_i,
  input  hsw_pkg::side_t      side_i,
  output logic [14:0]         mag_o,
  output hsw_pkg::side_t      side_o
);
  import hsw_pkg::*;

  // The value is n * 2^(ex - 35), plus a sticky fraction below the last bit of n.
  logic [23:0]       n_q;
  logic signed [6:0] ex_q;
  logic              sticky_q;
  logic [4:0]        l_q;
  side_t             side1_q;

  always_ff @(posedge clk_i) begin
    n_q      <= n_i;
    ex_q     <= ex_i;
    sticky_q <= sticky_i;
    l_q      <= lead_pos(n_i);
    side1_q  <= side_i;
  end

  logic signed [7:0] e_w, lo_w, sh_w;
  logic [5:0]        sh;
  logic              normal, ovf, guard, st, ru;
  logic [43:0]       ext, w, mask;
  logic [10:0]       kept;
  logic [4:0]        eb;
  logic [15:0]       sum;
  logic [14:0]       mag_d;

  always_comb begin
    e_w    = $signed({3'b000, l_q}) + $signed({ex_q[6], ex_q}) - 8'sd20;
    normal = (e_w >= 8'sd1);
    ovf    = (e_w >= 8'sd31);
    lo_w   = normal ? ($signed({3'b000, l_q}) - 8'sd10)
                    : (8'sd11 - $signed({ex_q[6], ex_q}));
    sh_w   = lo_w + 8'sd19;
    sh     = sh_w[5:0];
    ext    = {n_q, 20'b0};
    w      = ext >> sh;
    mask   = (44'd1 << sh) - 44'd1;
    guard  = w[0];
    kept   = w[11:1];
    st     = sticky_q | (|(ext & mask));
    ru     = guard & (st | kept[0]);
    eb     = normal ? (e_w[4:0] - 5'd1) : 5'd0;
    sum    = {1'b0, eb, 10'b0} + {5'b0, kept} + {15'b0, ru};
    if (n_q == 24'd0) begin
      mag_d = 15'd0;
    end else if (ovf) begin
      mag_d = MAG_INF;
    end else begin
      mag_d = sum[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_o  <= mag_d;
    side_o <= side1_q;
  end

endmodule

// ===== rtl/hsw_lane.sv =====
// One hard-swish lane: offset and clamp, multiply, round, divide by six, round.
module hsw_lane (
  input  logic        clk_i,
  input  logic [15:0] x_i,
  output logic [15:0] y_o
);
  import hsw_pkg::*;

  logic             s;
  logic [4:0]       e, ee;
  logic [9:0]       f;
  logic [10:0]      mant;
  logic [25:0]      xf;
  logic signed [27:0] v;
  logic [11:0]      tq;
  logic             ru;
  logic [12:0]      t, c;
  side_t            side_a;

  always_comb begin
    s    = x_i[15];
    e    = x_i[14:10];
    f    = x_i[9:0];
    mant = (e == 5'd0) ? {1'b0, f} : {1'b1, f};
    ee   = (e == 5'd0) ? 5'd1 : e;
    xf   = {15'b0, mant} << (ee - 5'd1);
    v    = s ? (THREE_FX - $signed({2'b00, xf})) : (THREE_FX + $signed({2'b00, xf}));
    tq   = 12'd0;
    ru   = 1'b0;
    t    = 13'd0;
    if (!v[27] && (v != 28'sd0)) begin
      if (v[26]) begin
        ru = v[15] & ((|v[14:0]) | v[16]);
        tq = {1'b0, v[26:16]} + {11'b0, ru};
        t  = {tq[10:0], 2'b00};
      end else if (v[25]) begin
        ru = v[14] & ((|v[13:0]) | v[15]);
        tq = {1'b0, v[25:15]} + {11'b0, ru};
        t  = {tq, 1'b0};
      end else begin
        ru = v[13] & ((|v[12:0]) | v[14]);
        tq = {1'b0, v[24:14]} + {11'b0, ru};
        t  = {1'b0, tq};
      end
    end
    if (e <= 5'd16) begin
      c = (t > C_SIX) ? C_SIX : t;
    end else begin
      c = s ? 13'd0 : C_SIX;
    end
    side_a.sign    = s;
    side_a.byp     = (e == 5'd31);
    side_a.byp_val = ((f != 10'd0) || s) ? FP16_QNAN : FP16_PINF;
  end

  logic [12:0] c_q;
  logic [10:0] mant_q;
  logic [4:0]  ee_q;
  side_t       side_a_q;

  always_ff @(posedge clk_i) begin
    c_q      <= c;
    mant_q   <= mant;
    ee_q     <= ee;
    side_a_q <= side_a;
  end

  logic [23:0]       prod_q;
  logic signed [6:0] ex_b_q;
  side_t             side_b_q;

  always_ff @(posedge clk_i) begin
    prod_q   <= c_q * {2'b00, mant_q};
    ex_b_q   <= $signed({2'b00, ee_q});
    side_b_q <= side_a_q;
  end

  logic [14:0] mag1;
  side_t       side1;

  hsw_rnd u_rnd_mul (
    .clk_i    (clk_i),
    .n_i      (prod_q),
    .ex_i     (ex_b_q),
    .sticky_i (1'b0),
    .side_i   (side_b_q),
    .mag_o    (mag1),
    .side_o   (side1)
  );

  logic [4:0]  em, eem;
  logic [10:0] mm;
  logic [23:0] nq;
  side_t       side_c;

  always_comb begin
    em     = mag1[14:10];
    mm     = (em == 5'd0) ? {1'b0, mag1[9:0]} : {1'b1, mag1[9:0]};
    eem    = (em == 5'd0) ? 5'd1 : em;
    nq     = {mm, 13'b0};
    side_c = side1;
    if (!side1.byp) begin
      if (mag1 == 15'd0) begin
        side_c.byp     = 1'b1;
        side_c.byp_val = {side1.sign, 15'd0};
      end else if (mag1 == MAG_INF) begin
        side_c.byp     = 1'b1;
        side_c.byp_val = {side1.sign, MAG_INF};
      end
    end
  end

  logic [47:0] dprod_q;
  logic [23:0] nq_q;
  logic [4:0]  eem_q;
  side_t       side_d_q;

  always_ff @(posedge clk_i) begin
    dprod_q  <= nq * RECIP3;
    nq_q     <= nq;
    eem_q    <= eem;
    side_d_q <= side_c;
  end

  logic [22:0] q23;
  logic [23:0] q3, rem;

  always_comb begin
    q23 = dprod_q[47:25];
    q3  = {q23, 1'b0} + {1'b0, q23};
    rem = nq_q - q3;
  end

  logic [23:0]       n2_q;
  logic signed [6:0] ex2_q;
  logic              st2_q;
  side_t             side_e_q;

  always_ff @(posedge clk_i) begin
    n2_q     <= {1'b0, q23};
    ex2_q    <= $signed({2'b00, eem_q}) - 7'sd4;
    st2_q    <= (rem != 24'd0);
    side_e_q <= side_d_q;
  end

  logic [14:0] mag2;
  side_t       side2;

  hsw_rnd u_rnd_div (
    .clk_i    (clk_i),
    .n_i      (n2_q),
    .ex_i     (ex2_q),
    .sticky_i (st2_q),
    .side_i   (side_e_q),
    .mag_o    (mag2),
    .side_o   (side2)
  );

  assign y_o = side2.byp ? side2.byp_val : {side2.sign, mag2};

endmodule

// ===== rtl/hard_swish_fp16_vector.sv =====
// Top level of the eight-lane fp16 hard-swish vector unit.
//
// Each transaction carries eight IEEE half-precision values and a lane count;
// the unit returns y = x * clamp(x + 3, 0, 6) / 6 in every lane, where the add,
// the multiply and the divide each round to nearest even. Lanes at or beyond
// the lane count return zero, a count above eight is taken as eight, and the
// count used is echoed on valid_lanes_o. The unit is fully pipelined: busy
// stays low, a new vector is taken in every cycle, and each result appears
// on the result ports for one cycle with done_o high. Each start reaches
// its result through the lane pipeline (offset and clamp, multiply, two
// normalize-and-round passes with the divide by six between them) and then
// the output merge register. The receiver cannot stall,
// so results must be taken when done_o is high.
module hard_swish_fp16_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] x_lane0_i,
  input  logic [15:0] x_lane1_i,
  input  logic [15:0] x_lane2_i,
  input  logic [15:0] x_lane3_i,
  input  logic [15:0] x_lane4_i,
  input  logic [15:0] x_lane5_i,
  input  logic [15:0] x_lane6_i,
  input  logic [15:0] x_lane7_i,
  input  logic [3:0]  lane_count_i,
  output logic        done_o,
  output logic [15:0] y_lane0_o,
  output logic [15:0] y_lane1_o,
  output logic [15:0] y_lane2_o,
  output logic [15:0] y_lane3_o,
  output logic [15:0] y_lane4_o,
  output logic [15:0] y_lane5_o,
  output logic [15:0] y_lane6_o,
  output logic [15:0] y_lane7_o,
  output logic [3:0]  valid_lanes_o
);
  import hsw_pkg::*;

  // The pipeline never stalls, so a start is always taken.
  assign busy = 1'b0;

  logic [15:0] x_w [LANES];
  logic [15:0] y_w [LANES];

  assign x_w[0] = x_lane0_i;
  assign x_w[1] = x_lane1_i;
  assign x_w[2] = x_lane2_i;
  assign x_w[3] = x_lane3_i;
  assign x_w[4] = x_lane4_i;
  assign x_w[5] = x_lane5_i;
  assign x_w[6] = x_lane6_i;
  assign x_w[7] = x_lane7_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    hsw_lane u_lane (
      .clk_i (clk_i),
      .x_i   (x_w[g]),
      .y_o   (y_w[g])
    );
  end

  // The lane count is saturated on entry and travels alongside the lanes.
  logic [CNT_W-1:0] cnt_in;
  assign cnt_in = (lane_count_i > CNT_W'(LANES)) ? CNT_W'(LANES) : lane_count_i;

  logic [LANE_LAT-1:0] vld_q;
  logic [CNT_W-1:0]    cnt_q [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LANE_LAT-2:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q[0] <= cnt_in;
    for (int i = 1; i < LANE_LAT; i++) begin
      cnt_q[i] <= cnt_q[i-1];
    end
  end

  // Merge stage: lanes past the count are forced to zero.
  logic             done_q;
  logic [15:0]      y_q [LANES];
  logic [CNT_W-1:0] vl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    vl_q <= cnt_q[LANE_LAT-1];
    for (int i = 0; i < LANES; i++) begin
      y_q[i] <= (CNT_W'(i) < cnt_q[LANE_LAT-1]) ? y_w[i] : 16'h0000;
    end
  end

  assign done_o        = done_q;
  assign valid_lanes_o = vl_q;
  assign y_lane0_o     = y_q[0];
  assign y_lane1_o     = y_q[1];
  assign y_lane2_o     = y_q[2];
  assign y_lane3_o     = y_q[3];
  assign y_lane4_o     = y_q[4];
  assign y_lane5_o     = y_q[5];
  assign y_lane6_o     = y_q[6];
  assign y_lane7_o     = y_q[7];

endmodule

// ===== rtl/hsw_chk.sv =====
// Port-level checker for the fp16 hard-swish vector unit, with its bind.
module hsw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [15:0] y_lane7_o,
  input logic [3:0]  valid_lanes_o
);

  // Every accepted transaction is followed by its result on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##9 done_o)
    else $error("result missing nine cycles after start");

  // No result appears without a matching start.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 9))
    else $error("result without a start");

  // The echoed lane count never exceeds the lane total.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (valid_lanes_o <= 4'd8))
    else $error("lane count out of range");

  // The top lane is zero whenever it lies past the count.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (valid_lanes_o < 4'd8)) |-> (y_lane7_o == 16'h0000))
    else $error("unused lane not zero");

endmodule

bind hard_swish_fp16_vector hsw_chk u_hsw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .y_lane7_o     (y_lane7_o),
  .valid_lanes_o (valid_lanes_o)
);
